FILE: sv/tcpf_pkg.sv
// Package for the two-class priority FIFO: request and response types,
// status and kind codes, and the controller-to-datapath command struct.
// No dependencies.
`default_nettype none

package tcpf_pkg;

   localparam int DEFAULT_CLASS_DEPTH = 16;
   localparam int VALUE_W             = 32;
   localparam int STATUS_W            = 2;
   localparam int OCC_W               = 6;

   // Request kinds.
   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] value;
      logic                      urgent;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] head_value;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   // Commands issued by the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic respond;
   } cmd_type;

endpackage

`default_nettype wire

FILE: sv/tcpf_ctrl.sv
// Controller for the two-class priority FIFO: sequences capture, execute
// and respond for one request at a time. Depends on tcpf_pkg.
`default_nettype none

module tcpf_ctrl
   import tcpf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.capture = (state_ff == ST_IDLE) && start;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign cmd.respond = (state_ff == ST_RESP);

endmodule

`default_nettype wire

FILE: sv/tcpf_datapath.sv
// Datapath for the two-class priority FIFO: request register, one ring
// memory with pointers and fill count per class, and response assembly.
// Depends on tcpf_pkg.
`default_nettype none

module tcpf_datapath
   import tcpf_pkg::*;
#(
   parameter int CLASS_DEPTH = DEFAULT_CLASS_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_item,
   output rsp_type      rsp_item
);

   localparam int PTR_W  = $clog2(CLASS_DEPTH);
   localparam int FILL_W = $clog2(CLASS_DEPTH + 1);

   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(CLASS_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CLASS_DEPTH);

   logic [VALUE_W-1:0] urg_mem [CLASS_DEPTH];
   logic [VALUE_W-1:0] nrm_mem [CLASS_DEPTH];

   req_type            req_ff;
   logic [PTR_W-1:0]   urg_rd_ff, urg_rd_in, urg_wr_ff, urg_wr_in;
   logic [PTR_W-1:0]   nrm_rd_ff, nrm_rd_in, nrm_wr_ff, nrm_wr_in;
   logic [FILL_W-1:0]  urg_fill_ff, urg_fill_in, nrm_fill_ff, nrm_fill_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic               pop_ff, pop_in;
   logic               pop_urg_ff, pop_urg_in;
   logic [VALUE_W-1:0] urg_rdata_ff, nrm_rdata_ff;
   logic               urg_we, nrm_we;
   logic [FILL_W:0]    total;
   logic [VALUE_W-1:0] head;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      urg_rd_in   = urg_rd_ff;
      urg_wr_in   = urg_wr_ff;
      nrm_rd_in   = nrm_rd_ff;
      nrm_wr_in   = nrm_wr_ff;
      urg_fill_in = urg_fill_ff;
      nrm_fill_in = nrm_fill_ff;
      status_in   = STATUS_OK;
      pop_in      = 1'b0;
      pop_urg_in  = 1'b0;
      urg_we      = 1'b0;
      nrm_we      = 1'b0;
      if (req_ff.kind == KIND_ENQ) begin
         if (req_ff.urgent) begin
            if (urg_fill_ff == FILL_MAX) begin
               status_in = STATUS_FULL;
            end else begin
               urg_we      = 1'b1;
               urg_wr_in   = ptr_next(urg_wr_ff);
               urg_fill_in = urg_fill_ff + 1'b1;
            end
         end else begin
            if (nrm_fill_ff == FILL_MAX) begin
               status_in = STATUS_FULL;
            end else begin
               nrm_we      = 1'b1;
               nrm_wr_in   = ptr_next(nrm_wr_ff);
               nrm_fill_in = nrm_fill_ff + 1'b1;
            end
         end
      end else begin
         priority if (urg_fill_ff != '0) begin
            pop_in      = 1'b1;
            pop_urg_in  = 1'b1;
            urg_rd_in   = ptr_next(urg_rd_ff);
            urg_fill_in = urg_fill_ff - 1'b1;
         end else if (nrm_fill_ff != '0) begin
            pop_in      = 1'b1;
            nrm_rd_in   = ptr_next(nrm_rd_ff);
            nrm_fill_in = nrm_fill_ff - 1'b1;
         end else begin
            status_in = STATUS_EMPTY;
         end
      end
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   // Ring control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         urg_rd_ff   <= '0;
         urg_wr_ff   <= '0;
         nrm_rd_ff   <= '0;
         nrm_wr_ff   <= '0;
         urg_fill_ff <= '0;
         nrm_fill_ff <= '0;
      end else if (cmd.execute) begin
         urg_rd_ff   <= urg_rd_in;
         urg_wr_ff   <= urg_wr_in;
         nrm_rd_ff   <= nrm_rd_in;
         nrm_wr_ff   <= nrm_wr_in;
         urg_fill_ff <= urg_fill_in;
         nrm_fill_ff <= nrm_fill_in;
      end
   end

   // Outcome of the executed request.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         pop_ff     <= pop_in;
         pop_urg_ff <= pop_urg_in;
      end
   end

   // Ring memories: write at the tail, registered read at the head.
   always_ff @(posedge clock) begin
      if (cmd.execute && urg_we) begin
         urg_mem[urg_wr_ff] <= req_ff.value;
      end
      if (cmd.execute) begin
         urg_rdata_ff <= urg_mem[urg_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && nrm_we) begin
         nrm_mem[nrm_wr_ff] <= req_ff.value;
      end
      if (cmd.execute) begin
         nrm_rdata_ff <= nrm_mem[nrm_rd_ff];
      end
   end

   assign total = {1'b0, urg_fill_ff} + {1'b0, nrm_fill_ff};
   assign head  = !pop_ff    ? '0 :
                  pop_urg_ff ? urg_rdata_ff : nrm_rdata_ff;

   assign rsp_item.status     = status_ff;
   assign rsp_item.head_value = head;
   assign rsp_item.occupancy  = OCC_W'(total);

endmodule

`default_nettype wire

FILE: sv/two_class_priority_fifo_core.sv
// Top level of the two-class priority FIFO: controller plus datapath.
// Depends on tcpf_pkg, tcpf_ctrl and tcpf_datapath.
`default_nettype none

// Usage:
// The block is a strict two-level priority queue with one ring per class.
// A request transfer happens at a rising edge where start is high and busy
// is low; req_item carries kind (enqueue or dequeue), a signed value and the
// urgent flag. Urgent values always leave before normal values, and each
// class is first-in first-out.
// Every request yields exactly one response transfer: rsp_strobe is high for
// one cycle while rsp_item holds the status (ok, empty on a dequeue, full on
// an enqueue whose value is dropped), the dequeued value (zero otherwise) and
// the total occupancy after the request.
// Each request passes through the idle cycle that ends in the request
// transfer, execute (ring update and the registered memory read at the head
// pointer), then the response cycle. The response is on the ports in the
// cycle right after the request transfer's execute cycle. Busy stays high
// until the response cycle has ended, so a new request is taken only after
// the previous one is through. The controller's one-request-at-a-time
// sequence and the registered memory read set this pacing.
// Reset clears the pointers, fill counts and controller; ring contents are
// not cleared, and only values at positions that were written are returned.
// The receiver cannot stall: it must take the response in its strobe cycle.

module two_class_priority_fifo_core
   import tcpf_pkg::*;
#(
   parameter int CLASS_DEPTH = DEFAULT_CLASS_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   cmd_type cmd;

   // The controller steps one request through its three phases.
   tcpf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath holds both rings and forms the response.
   tcpf_datapath #(
      .CLASS_DEPTH (CLASS_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   // The response is valid during the respond phase only.
   assign rsp_strobe = cmd.respond;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for two_class_priority_fifo_core: directed and random
// enqueue/dequeue traffic scored against an in-bench model of the two rings.
// Depends on tcpf_pkg and the RTL under sv/.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcpf_pkg::*;

   // The bench model is sized like the instance below.
   localparam int DEPTH        = DEFAULT_CLASS_DEPTH;
   localparam int NORMAL_CLASS = 0;
   localparam int URGENT_CLASS = 1;
   localparam int RANDOM_ITEMS = 422;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // The bench model of the queue: one ring per class, indexed by class.
   logic signed [VALUE_W-1:0] class_store [2][DEPTH];
   int                        read_ptr [2] = '{0, 0};
   int                        write_ptr[2] = '{0, 0};
   int                        fill     [2] = '{0, 0};

   // Responses still owed by the DUT, oldest first.
   rsp_type pending_rsp[$];
   rsp_type want;
   int      errors     = 0;
   int      burst_left = 0;
   // Tracks whether start is currently being held high by the sender, so that
   // the drain logic knows whether it has to lower it.
   bit      start_high = 1'b0;

   two_class_priority_fifo_core #(
      .CLASS_DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   // Applies one accepted request to the bench model and returns the response
   // the DUT must give for it. An enqueue picks its class by the urgent flag; a
   // dequeue always drains the urgent ring before touching the normal one.
   function automatic rsp_type queue_response(input req_type r);
      rsp_type res;
      int      cls;
      res.status     = STATUS_OK;
      res.head_value = '0;
      if (r.kind == KIND_ENQ) begin
         cls = r.urgent ? URGENT_CLASS : NORMAL_CLASS;
         if (fill[cls] >= DEPTH) begin
            // A full class drops the value; the other class never takes it.
            res.status = STATUS_FULL;
         end else begin
            class_store[cls][write_ptr[cls]] = r.value;
            write_ptr[cls] = (write_ptr[cls] + 1) % DEPTH;
            fill[cls]++;
         end
      end else begin
         if (fill[URGENT_CLASS] > 0) begin
            cls = URGENT_CLASS;
         end else if (fill[NORMAL_CLASS] > 0) begin
            cls = NORMAL_CLASS;
         end else begin
            cls = -1;
         end
         if (cls < 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.head_value = class_store[cls][read_ptr[cls]];
            read_ptr[cls] = (read_ptr[cls] + 1) % DEPTH;
            fill[cls]--;
         end
      end
      res.occupancy = OCC_W'(fill[URGENT_CLASS] + fill[NORMAL_CLASS]);
      return res;
   endfunction

   function automatic req_type make_req(input logic kind, input logic signed [VALUE_W-1:0] v,
                                        input logic urg);
      req_type r;
      r.kind   = kind;
      r.value  = v;
      r.urgent = urg;
      return r;
   endfunction

   // Values lean toward the extremes and the sign boundary, but half are
   // fully random so every bit gets exercised.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(VALUE_W-1){1'b0}}};
         1: return {1'b0, {(VALUE_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Sends one request. The item is put on the bus with start high, and the
   // transfer happens at the first rising edge where busy was low. The bench
   // model is advanced at that same edge. The sender works in bursts: at the
   // end of each burst it drops start for a random gap, so that new requests
   // land at every point of the DUT's request sequence.
   task automatic send_req(input req_type item);
      int gap;
      start      <= 1'b1;
      req_item   <= item;
      start_high = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_rsp.push_back(queue_response(item));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = $urandom_range(1, 7);
         start      <= 1'b0;
         start_high = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender off until every owed response has come back. The wait
   // always spans an edge, so start never gets two assignments in one step.
   task automatic drain_responses();
      if (start_high) begin
         start      <= 1'b0;
         start_high = 1'b0;
      end
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // A dequeue from the empty queue must report empty with a zero value.
   task automatic test_empty_dequeue();
      send_req(make_req(KIND_DEQ, $urandom, 1'b1));
      drain_responses();
   endtask

   // Urgent values leave first even when they arrive later, each class stays
   // first-in first-out, and the final dequeue finds the queue empty again.
   task automatic test_priority_order();
      send_req(make_req(KIND_ENQ, {1'b1, {(VALUE_W-1){1'b0}}}, 1'b0));
      send_req(make_req(KIND_ENQ, {1'b0, {(VALUE_W-1){1'b1}}}, 1'b1));
      send_req(make_req(KIND_ENQ, '1, 1'b0));
      send_req(make_req(KIND_ENQ, '0, 1'b1));
      repeat (5) send_req(make_req(KIND_DEQ, $urandom, 1'($urandom_range(0, 1))));
      drain_responses();
   endtask

   // Fills the urgent ring to the brim, shows that one more urgent value is
   // dropped as full, and that the normal ring still takes a value.
   task automatic test_class_full();
      repeat (DEPTH) send_req(make_req(KIND_ENQ, pick_value(), 1'b1));
      send_req(make_req(KIND_ENQ, pick_value(), 1'b1));
      send_req(make_req(KIND_ENQ, pick_value(), 1'b0));
      drain_responses();
   endtask

   // Random traffic in phases. Each phase has its own mix of enqueues and
   // dequeues, so the rings swing between full and empty and the pointers
   // wrap many times. Dequeues carry random value and urgent bits too, since
   // the DUT must ignore them.
   task automatic test_random_traffic(input int total);
      int enq_bias[5] = '{85, 15, 55, 70, 30};
      int sent        = 0;
      int phase       = 0;
      int phase_len;
      int urgent_pct;
      req_type r;
      while (sent < total) begin
         phase_len = $urandom_range(20, 60);
         case ($urandom_range(0, 3))
            0: urgent_pct = 0;
            1: urgent_pct = 100;
            default: urgent_pct = $urandom_range(0, 100);
         endcase
         for (int i = 0; i < phase_len && sent < total; i++) begin
            r.kind   = ($urandom_range(0, 99) < enq_bias[phase % 5]) ? KIND_ENQ : KIND_DEQ;
            r.value  = pick_value();
            r.urgent = ($urandom_range(0, 99) < urgent_pct);
            send_req(r);
            sent++;
         end
         phase++;
         // Wait out all owed responses now and then, and always once early.
         if (phase == 2 || $urandom_range(0, 3) == 0) begin
            drain_responses();
         end
      end
      drain_responses();
   endtask

   // Response checker. Outputs are sampled at the rising edge, which sees the
   // values of the cycle that edge ends, so a strobe seen here is one transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ($isunknown(rsp_strobe)) begin
            $error("rsp_strobe is unknown");
            errors++;
         end else if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $error("response transfer with no request outstanding");
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  errors++;
               end
               if (rsp_item.head_value !== want.head_value) begin
                  $error("head_value: expected %0d, actual %0d",
                         want.head_value, rsp_item.head_value);
                  errors++;
               end
               if (rsp_item.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, actual %0d",
                         want.occupancy, rsp_item.occupancy);
                  errors++;
               end
            end
         end
      end
   end

   // Main sequence: reset once, run each test in turn, then wait for the last
   // responses plus a few spare cycles before giving the verdict.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_dequeue();
      test_priority_order();
      test_class_full();
      test_random_traffic(RANDOM_ITEMS);
      repeat (8) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: a correct run needs well under a tenth of this.
   initial begin
      #1ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
